// ===== sv/olst_pkg.sv =====
`default_nettype none

package olst_pkg;

  // List geometry.
  localparam int CAPACITY   = 16;
  localparam int DATA_WIDTH = 16;
  localparam int IDX_W      = $clog2(CAPACITY);
  localparam int CNT_W      = $clog2(CAPACITY + 1);

  // Request field widths.
  localparam int ACT_W  = 4;
  localparam int RIDX_W = 6;
  localparam int STAT_W = 3;

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 4'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 4'd1;
  localparam logic [ACT_W-1:0] ACT_INSERT_AT  = 4'd2;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 4'd3;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 4'd4;
  localparam logic [ACT_W-1:0] ACT_DELETE_AT  = 4'd5;
  localparam logic [ACT_W-1:0] ACT_DELETE_VAL = 4'd6;
  localparam logic [ACT_W-1:0] ACT_SEARCH     = 4'd7;
  localparam logic [ACT_W-1:0] ACT_READ_AT    = 4'd8;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK      = 3'd0;
  localparam logic [STAT_W-1:0] ST_RANGE   = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STAT_W-1:0] ST_MISSING = 3'd4;

  // Cell operations.
  localparam logic [1:0] OP_NOP   = 2'd0;
  localparam logic [1:0] OP_OPEN  = 2'd1;
  localparam logic [1:0] OP_CLOSE = 2'd2;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic [1:0]            op;
    logic [IDX_W-1:0]      at;
    logic [DATA_WIDTH-1:0] value;
    logic                  cmp;
  } olst_cmd_t;

endpackage

`default_nettype wire

// ===== sv/ordered_list_engine_unit.sv =====
// Ordered list engine: a bounded list of up to 16 entries of 16 bits, held
// in a chain of cells that shift in parallel to open or close a gap.
// Input channel: in_valid / in_stall carry a request (action, value, index).
// A request is taken at a clock edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall carry one result per request
// (status, data, position, count).
// After a request is taken, the engine passes through a compare state (S_CMP),
// in which the cells register their compare against the value, and an apply
// state (S_APPLY), in which the action is applied and the result registered.
// The engine handles one request at a time and takes the next one only once
// it is back in idle, after the compare pass and the update pass.
// When the receiver stalls, the finished result is held in the output
// register and the engine waits with the next update until it is taken.
// Reset empties the list and clears the output valid flag; a request can be
// taken in the first cycle after reset. The entry contents are left as they
// are and are never read before being written.
`default_nettype none

module ordered_list_engine_unit (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               in_valid,
  output logic                              in_stall,
  input  wire [olst_pkg::ACT_W-1:0]         action,
  input  wire [olst_pkg::DATA_WIDTH-1:0]    value,
  input  wire signed [olst_pkg::RIDX_W-1:0] index,
  output logic                              out_valid,
  input  wire                               out_stall,
  output logic [olst_pkg::STAT_W-1:0]       status,
  output logic [olst_pkg::DATA_WIDTH-1:0]   data,
  output logic [olst_pkg::IDX_W-1:0]        position,
  output logic [olst_pkg::CNT_W-1:0]        count
);
  import olst_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_CMP   = 2'd1;
  localparam logic [1:0] S_APPLY = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [ACT_W-1:0]      r_action;
  logic [DATA_WIDTH-1:0] r_value;
  logic [RIDX_W-1:0]     r_index;
  logic [CNT_W-1:0]      cnt;
  logic [CNT_W-1:0]      cnt_next;

  logic [CAPACITY-1:0][DATA_WIDTH-1:0] entries;
  logic [CAPACITY-1:0]   hits;
  olst_cmd_t             cmd;

  logic                  fire;
  logic                  in_take;
  logic                  out_take;
  logic [STAT_W-1:0]     st;
  logic [DATA_WIDTH-1:0] rd;
  logic [IDX_W-1:0]      pos;
  logic [1:0]            op;
  logic [IDX_W-1:0]      at;

  logic                  neg;
  logic                  idx_gt_cnt;
  logic                  idx_ge_cnt;
  logic                  full;
  logic                  empty;
  logic signed [RIDX_W:0] back_sum;
  logic [IDX_W-1:0]      read_slot;
  logic [CAPACITY-1:0]   live;
  logic                  found;
  logic [IDX_W-1:0]      first;

  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;
  assign in_stall = (state != S_IDLE);
  assign fire     = (state == S_APPLY) && (!out_valid || !out_stall);

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_CMP;
      S_CMP:   state_next = S_APPLY;
      S_APPLY: if (fire) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (fire) begin
        cnt <= cnt_next;
      end
    end
  end

  // Request capture.
  always_ff @(posedge clk) begin
    if (in_take) begin
      r_action <= action;
      r_value  <= value;
      r_index  <= index;
    end
  end

  // First matching live entry.
  always_comb begin
    found = 1'b0;
    first = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      live[i] = (CNT_W'(i) < cnt);
      if (!found && live[i] && hits[i]) begin
        found = 1'b1;
        first = IDX_W'(i);
      end
    end
  end

  // Index checks.
  assign neg        = r_index[RIDX_W-1];
  assign idx_gt_cnt = !neg && ({1'b0, r_index} > (RIDX_W + 1)'(cnt));
  assign idx_ge_cnt = !neg && ({1'b0, r_index} >= (RIDX_W + 1)'(cnt));
  assign full       = (cnt == CNT_W'(CAPACITY));
  assign empty      = (cnt == '0);
  assign back_sum   = $signed({r_index[RIDX_W-1], r_index}) + $signed((RIDX_W + 1)'(cnt));
  assign read_slot  = neg ? back_sum[IDX_W-1:0] : r_index[IDX_W-1:0];

  // Action decode.
  always_comb begin
    st       = ST_OK;
    rd       = '0;
    pos      = '0;
    op       = OP_NOP;
    at       = '0;
    cnt_next = cnt;
    unique case (r_action)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (full) begin
          st = ST_FULL;
        end else begin
          op       = OP_OPEN;
          at       = (r_action == ACT_PUSH_BACK) ? cnt[IDX_W-1:0] : '0;
          cnt_next = cnt + 1'b1;
        end
      end
      ACT_INSERT_AT: begin
        if (neg || idx_gt_cnt) begin
          st = ST_RANGE;
        end else if (full) begin
          st = ST_FULL;
        end else begin
          op       = OP_OPEN;
          at       = r_index[IDX_W-1:0];
          cnt_next = cnt + 1'b1;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (empty) begin
          st = ST_EMPTY;
        end else begin
          op       = OP_CLOSE;
          at       = (r_action == ACT_POP_FRONT) ? '0 : IDX_W'(cnt - 1'b1);
          cnt_next = cnt - 1'b1;
        end
      end
      ACT_DELETE_AT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (neg || idx_ge_cnt) begin
          st = ST_RANGE;
        end else begin
          op       = OP_CLOSE;
          at       = r_index[IDX_W-1:0];
          cnt_next = cnt - 1'b1;
        end
      end
      ACT_DELETE_VAL, ACT_SEARCH: begin
        if (!found) begin
          st = ST_MISSING;
        end else begin
          pos = first;
          if (r_action == ACT_DELETE_VAL) begin
            op       = OP_CLOSE;
            at       = first;
            cnt_next = cnt - 1'b1;
          end
        end
      end
      ACT_READ_AT: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if ((neg && back_sum[RIDX_W]) || idx_ge_cnt) begin
          st = ST_RANGE;
        end else begin
          rd = entries[read_slot];
        end
      end
      default: begin
      end
    endcase
  end

  // Command to the cell chain.
  always_comb begin
    cmd.op    = fire ? op : OP_NOP;
    cmd.at    = at;
    cmd.value = r_value;
    cmd.cmp   = (state == S_CMP);
  end

  olst_chain u_chain (
    .clk     (clk),
    .cmd     (cmd),
    .entries (entries),
    .hits    (hits)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status   <= st;
      data     <= rd;
      position <= pos;
      count    <= cnt_next;
    end
  end

endmodule

`default_nettype wire

// ===== sv/olst_cell.sv =====
`default_nettype none

module olst_cell (
  input  wire                         clk,
  input  wire olst_pkg::olst_cmd_t    cmd,
  input  wire [olst_pkg::IDX_W-1:0]   slot,
  input  wire [olst_pkg::DATA_WIDTH-1:0] from_lower,
  input  wire [olst_pkg::DATA_WIDTH-1:0] from_upper,
  output logic [olst_pkg::DATA_WIDTH-1:0] entry,
  output logic                        match
);
  import olst_pkg::*;

  // Entry update: open a gap (shift towards the back) or close one.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_OPEN: begin
        if (slot == cmd.at) begin
          entry <= cmd.value;
        end else if (slot > cmd.at) begin
          entry <= from_lower;
        end
      end
      OP_CLOSE: begin
        if (slot >= cmd.at) begin
          entry <= from_upper;
        end
      end
      default: begin
      end
    endcase
  end

  // Registered compare against the searched value.
  always_ff @(posedge clk) begin
    if (cmd.cmp) begin
      match <= (entry == cmd.value);
    end
  end

endmodule

`default_nettype wire

// ===== sv/olst_chain.sv =====
`default_nettype none

module olst_chain (
  input  wire                  clk,
  input  wire olst_pkg::olst_cmd_t cmd,
  output logic [olst_pkg::CAPACITY-1:0][olst_pkg::DATA_WIDTH-1:0] entries,
  output logic [olst_pkg::CAPACITY-1:0] hits
);
  import olst_pkg::*;

  logic [CAPACITY-1:0][DATA_WIDTH-1:0] lower;
  logic [CAPACITY-1:0][DATA_WIDTH-1:0] upper;

  // Neighbour links; the ends of the chain see zero.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      lower[i] = (i == 0) ? '0 : entries[(i == 0) ? 0 : i - 1];
      upper[i] = (i == CAPACITY - 1) ? '0 : entries[(i == CAPACITY - 1) ? i : i + 1];
    end
  end

  // One cell per list position.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    olst_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .slot       (IDX_W'(g)),
      .from_lower (lower[g]),
      .from_upper (upper[g]),
      .entry      (entries[g]),
      .match      (hits[g])
    );
  end

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import olst_pkg::*;

  // Action codes the engine treats as no-ops.
  localparam logic [ACT_W-1:0] ACT_UNUSED_FIRST = 4'd9;
  localparam logic [ACT_W-1:0] ACT_UNUSED_LAST  = 4'd15;

  localparam int CLK_HALF     = 4;
  localparam int RESET_CYCLES = 5;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int RANDOM_ITEMS = 1700;
  localparam int STEADY_ITEMS = 300;

  typedef enum int {MIX_GROW, MIX_SHRINK, MIX_BALANCED} traffic_mix_t;

  typedef struct packed {
    logic [STAT_W-1:0]     status;
    logic [DATA_WIDTH-1:0] data;
    logic [IDX_W-1:0]      position;
    logic [CNT_W-1:0]      count;
  } list_result_t;

  logic                         clk;
  logic                         rst;
  logic                         in_valid;
  logic                         in_stall;
  logic [ACT_W-1:0]             action;
  logic [DATA_WIDTH-1:0]        value;
  logic signed [RIDX_W-1:0]     index;
  logic                         out_valid;
  logic                         out_stall;
  logic [STAT_W-1:0]            status;
  logic [DATA_WIDTH-1:0]        data;
  logic [IDX_W-1:0]             position;
  logic [CNT_W-1:0]             count;

  // Shadow copy of the list, updated as each request is taken.
  logic [DATA_WIDTH-1:0] list_store [CAPACITY];
  int                    list_len = 0;

  list_result_t expected_results [$];
  int           fail_count   = 0;
  int           cycle_count  = 0;
  int           send_gap_pct = 0;
  int           stall_pct    = 0;

  ordered_list_engine_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .action    (action),
    .value     (value),
    .index     (index),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .data      (data),
    .position  (position),
    .count     (count)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Shift entries back by one from the given position and store the new value there.
  function automatic void open_slot(input int at, input logic [DATA_WIDTH-1:0] v);
    for (int i = list_len; i > at; i--) list_store[i] = list_store[i-1];
    list_store[at] = v;
    list_len++;
  endfunction

  // Remove the entry at the given position, closing the gap behind it.
  function automatic void close_slot(input int at);
    for (int i = at; i + 1 < list_len; i++) list_store[i] = list_store[i+1];
    list_len--;
  endfunction

  // Apply one action to the shadow list and return the result it should produce.
  function automatic list_result_t apply_action(input logic [ACT_W-1:0] act,
                                                input logic [DATA_WIDTH-1:0] val,
                                                input logic signed [RIDX_W-1:0] idx);
    list_result_t res;
    int ix;
    int hit;
    res = '0;
    res.status = ST_OK;
    ix = idx;
    hit = -1;
    case (act)
      ACT_PUSH_BACK, ACT_PUSH_FRONT: begin
        if (list_len >= CAPACITY) res.status = ST_FULL;
        else open_slot((act == ACT_PUSH_BACK) ? list_len : 0, val);
      end
      ACT_INSERT_AT: begin
        if (ix < 0 || ix > list_len) res.status = ST_RANGE;
        else if (list_len >= CAPACITY) res.status = ST_FULL;
        else open_slot(ix, val);
      end
      ACT_POP_FRONT, ACT_POP_BACK: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else close_slot((act == ACT_POP_FRONT) ? 0 : list_len - 1);
      end
      ACT_DELETE_AT: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (ix < 0 || ix >= list_len) res.status = ST_RANGE;
        else close_slot(ix);
      end
      ACT_DELETE_VAL, ACT_SEARCH: begin
        for (int i = 0; i < list_len && hit < 0; i++) begin
          if (list_store[i] == val) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_MISSING;
        end else begin
          res.position = IDX_W'(hit);
          if (act == ACT_DELETE_VAL) close_slot(hit);
        end
      end
      ACT_READ_AT: begin
        if (list_len == 0) res.status = ST_EMPTY;
        else if (ix < -list_len || ix >= list_len) res.status = ST_RANGE;
        else res.data = list_store[(ix < 0) ? list_len + ix : ix];
      end
      default: begin
      end
    endcase
    res.count = CNT_W'(list_len);
    return res;
  endfunction

  task automatic log_failure(input string what);
    $display("ERROR @%0t: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [DATA_WIDTH-1:0] got,
                             input logic [DATA_WIDTH-1:0] want);
    if (got !== want) log_failure($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // Present one request, wait for it to be taken and record the result it should give.
  task automatic send_request(input logic [ACT_W-1:0] act, input logic [DATA_WIDTH-1:0] val,
                              input int idx);
    int gap;
    if (send_gap_pct > 0 && $urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 7);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    action   = act;
    value    = val;
    index    = RIDX_W'(idx);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(apply_action(act, val, RIDX_W'(idx)));
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // Receiver: stalls come in random bursts.
  initial begin
    int stall_left;
    stall_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_stall = 1'b1;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  // Compare every result taken against the oldest outstanding expectation.
  always @(posedge clk) begin
    list_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        log_failure($sformatf("unexpected result: status %0d count %0d", status, count));
      end else begin
        want = expected_results.pop_front();
        check_field("status", DATA_WIDTH'(status), DATA_WIDTH'(want.status));
        check_field("data", data, want.data);
        check_field("position", DATA_WIDTH'(position), DATA_WIDTH'(want.position));
        check_field("count", DATA_WIDTH'(count), DATA_WIDTH'(want.count));
      end
    end
  end

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 15;
      default: return 40;
    endcase
  endfunction

  // Weight the actions so the list spends time both near full and near empty.
  function automatic logic [ACT_W-1:0] pick_action(input traffic_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 24) == 0) begin
      return ACT_W'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
    end
    case (mix)
      MIX_GROW: begin
        if (r < 25) return ACT_PUSH_BACK;
        if (r < 45) return ACT_PUSH_FRONT;
        if (r < 65) return ACT_INSERT_AT;
        return ACT_W'($urandom_range(ACT_POP_FRONT, ACT_READ_AT));
      end
      MIX_SHRINK: begin
        if (r < 20) return ACT_POP_FRONT;
        if (r < 40) return ACT_POP_BACK;
        if (r < 60) return ACT_DELETE_AT;
        if (r < 75) return ACT_DELETE_VAL;
        return ACT_W'($urandom_range(ACT_PUSH_BACK, ACT_READ_AT));
      end
      default: return ACT_W'($urandom_range(ACT_PUSH_BACK, ACT_READ_AT));
    endcase
  endfunction

  // Mostly values already held, so that searches and deletes find matches.
  function automatic logic [DATA_WIDTH-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60 && list_len > 0) return list_store[$urandom_range(0, list_len - 1)];
    if (r < 80) return DATA_WIDTH'($urandom_range(0, 7));
    return DATA_WIDTH'($urandom);
  endfunction

  // Mostly indexes around the live range, with the odd one anywhere in the field's range.
  function automatic int pick_index();
    if ($urandom_range(0, 99) < 80) begin
      return int'($urandom_range(0, 2 * list_len + 1)) - list_len;
    end
    return int'($urandom_range(0, 63)) - 32;
  endfunction

  // Every action that needs entries, issued on an empty list, then an out-of-range insert and an unused action code.
  task automatic test_empty_list();
    send_request(ACT_POP_FRONT, 16'h0000, 0);
    send_request(ACT_POP_BACK, 16'h0000, 0);
    send_request(ACT_DELETE_AT, 16'h0000, 0);
    send_request(ACT_READ_AT, 16'h0000, -1);
    send_request(ACT_SEARCH, 16'h0000, 0);
    send_request(ACT_DELETE_VAL, 16'hFFFF, 0);
    send_request(ACT_INSERT_AT, 16'h0001, 1);
    send_request(ACT_UNUSED_LAST, 16'hFFFF, -16);
  endtask

  // Fill the list using every way of adding an entry, with extreme values first.
  task automatic test_fill_to_capacity();
    send_request(ACT_PUSH_BACK, 16'h0000, 0);
    send_request(ACT_PUSH_FRONT, 16'hFFFF, 0);
    send_request(ACT_INSERT_AT, 16'h5555, 1);
    send_request(ACT_INSERT_AT, 16'hAAAA, 3);
    for (int i = 0; i < CAPACITY - 4; i++) begin
      send_request((i % 2) ? ACT_PUSH_FRONT : ACT_PUSH_BACK, DATA_WIDTH'((i + 1) * 16'h0101), 0);
    end
  endtask

  // Additions and reads at the edges of a full list.
  task automatic test_full_list_limits();
    send_request(ACT_PUSH_BACK, 16'h1234, 0);
    send_request(ACT_INSERT_AT, 16'h1234, 16);
    send_request(ACT_INSERT_AT, 16'h1234, -1);
    send_request(ACT_READ_AT, 16'h0000, -16);
    send_request(ACT_READ_AT, 16'h0000, 15);
    send_request(ACT_READ_AT, 16'h0000, 16);
  endtask

  // Removal by index and by value, searches that hit and miss, and a read from the back.
  task automatic test_edit_and_search();
    send_request(ACT_DELETE_AT, 16'h0000, 16);
    send_request(ACT_DELETE_AT, 16'h0000, -1);
    send_request(ACT_SEARCH, 16'hAAAA, 0);
    send_request(ACT_DELETE_VAL, 16'h5555, 0);
    send_request(ACT_SEARCH, 16'h5555, 0);
    send_request(ACT_DELETE_AT, 16'h0000, 0);
    send_request(ACT_POP_BACK, 16'h0000, 0);
    send_request(ACT_READ_AT, 16'h0000, -1);
  endtask

  // Random requests in blocks, each with its own mix and idling pattern.
  task automatic test_random_traffic(input int target);
    int sent;
    int n;
    traffic_mix_t mix;
    logic [ACT_W-1:0] act;
    sent = 0;
    while (sent < target) begin
      mix = traffic_mix_t'($urandom_range(0, 2));
      send_gap_pct = pick_idle_pct();
      stall_pct = pick_idle_pct();
      for (n = 0; n < 60 && sent < target; n++) begin
        act = pick_action(mix);
        send_request(act, pick_value(), pick_index());
        if (act <= ACT_READ_AT) sent++;
      end
    end
  endtask

  // Closing stretch at full rate on both sides.
  task automatic test_steady_stream(input int target);
    int sent;
    logic [ACT_W-1:0] act;
    sent = 0;
    send_gap_pct = 0;
    stall_pct = 0;
    while (sent < target) begin
      act = pick_action(traffic_mix_t'((sent / 50) % 3));
      send_request(act, pick_value(), pick_index());
      if (act <= ACT_READ_AT) sent++;
    end
  endtask

  initial begin
    rst      = 1'b1;
    in_valid = 1'b0;
    action   = ACT_PUSH_BACK;
    value    = '0;
    index    = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst = 1'b0;

    send_gap_pct = 20;
    stall_pct = 20;
    test_empty_list();
    test_fill_to_capacity();
    test_full_list_limits();
    test_edit_and_search();
    test_random_traffic(RANDOM_ITEMS);
    test_steady_stream(STEADY_ITEMS);

    // Let the last results drain, then allow for any stray extra result.
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/olst_pkg.sv
sv/olst_cell.sv
sv/olst_chain.sv
sv/ordered_list_engine_unit.sv
tb/testbench.sv
